/* src/wireless_power_id_config_phase_macros.svh */
// assertion helpers shared by the identification and configuration phase block
`ifndef WIRELESS_POWER_ID_CONFIG_PHASE_MACROS_SVH
`define WIRELESS_POWER_ID_CONFIG_PHASE_MACROS_SVH

// property that must hold at every clock edge out of reset
`define WPID_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define WPID_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* src/wpid_pkg.sv */
`timescale 1ns / 1ps

package wpid_pkg;

    // packet headers
    localparam logic [7:0] ID_HEADER      = 8'd113;
    localparam logic [7:0] XID_HEADER     = 8'd129;
    localparam logic [7:0] CFG_HEADER     = 8'd81;
    localparam logic [7:0] HOLDOFF_HEADER = 8'd6;
    localparam logic [7:0] OPT_HDR_LO     = 8'h18;
    localparam logic [7:0] OPT_HDR_HI     = 8'h29;

    // length and range limits
    localparam logic [7:0] ID_MIN_LEN   = 8'd6;
    localparam logic [7:0] CFG_MIN_LEN  = 8'd5;
    localparam logic [7:0] HOLDOFF_MIN  = 8'd5;
    localparam logic [7:0] HOLDOFF_MAX  = 8'd100;
    localparam logic [7:0] OPT_CNT_MAX  = 8'hFF;

    // phase codes as reported on the result
    localparam logic [2:0] PH_CODE_WAIT_ID  = 3'd0;
    localparam logic [2:0] PH_CODE_WAIT_XID = 3'd1;
    localparam logic [2:0] PH_CODE_OPTIONAL = 3'd2;
    localparam logic [2:0] PH_CODE_CONFIG   = 3'd3;
    localparam logic [2:0] PH_CODE_COMPLETE = 3'd4;
    localparam logic [2:0] PH_CODE_ERROR    = 3'd5;

    // fault codes
    localparam logic [2:0] FLT_NONE       = 3'd0;
    localparam logic [2:0] FLT_SHORT_ID   = 3'd1;
    localparam logic [2:0] FLT_BAD_CFG    = 3'd2;
    localparam logic [2:0] FLT_COUNT      = 3'd3;
    localparam logic [2:0] FLT_HOLDOFF    = 3'd4;
    localparam logic [2:0] FLT_UNEXPECTED = 3'd5;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 80;

    // sequencer states, one-hot
    typedef enum logic [5:0] {
        S_WAIT_ID  = 6'b000001,
        S_WAIT_XID = 6'b000010,
        S_OPTIONAL = 6'b000100,
        S_CONFIG   = 6'b001000,
        S_COMPLETE = 6'b010000,
        S_ERROR    = 6'b100000
    } t_phase;

    // classified packet, front to back
    typedef struct packed {
        logic        restart;
        logic        is_id;
        logic        is_xid;
        logic        is_cfg;
        logic        is_hold;
        logic        is_range;
        logic        len_id_ok;
        logic        len_cfg_ok;
        logic        hold_ok;
        logic [7:0]  id_version;
        logic [15:0] manufacturer;
        logic        ext_flag;
        logic [22:0] dev_id;
        logic [5:0]  ref_power;
        logic [2:0]  opt_count;
        logic [6:0]  win_size;
        logic        win_ok;
        logic [4:0]  win_offset;
        logic [2:0]  fsk_depth;
        logic        mode;
    } t_cmd;

endpackage

/* src/wpid_front.sv */
`timescale 1ns / 1ps

module wpid_front
    import wpid_pkg::*;
(
    input  logic                 i_valid,
    input  logic                 i_ready,
    input  logic                 i_req_type,
    input  logic [IN_DATA_W-1:0] i_data,
    output logic                 o_push,
    output t_cmd                 o_cmd
);

    logic [7:0] w_hdr;
    logic [7:0] w_len;
    logic [7:0] w_b0, w_b1, w_b2, w_b3, w_b4, w_b5;

    assign w_hdr = i_data[7:0];
    assign w_len = i_data[15:8];
    assign w_b0  = i_data[23:16];
    assign w_b1  = i_data[31:24];
    assign w_b2  = i_data[39:32];
    assign w_b3  = i_data[47:40];
    assign w_b4  = i_data[55:48];
    assign w_b5  = i_data[63:56];

    assign o_push = i_valid & i_ready;

    always_comb begin
        o_cmd.restart      = ~i_req_type;
        o_cmd.is_id        = (w_hdr == ID_HEADER);
        o_cmd.is_xid       = (w_hdr == XID_HEADER);
        o_cmd.is_cfg       = (w_hdr == CFG_HEADER);
        o_cmd.is_hold      = (w_hdr == HOLDOFF_HEADER);
        o_cmd.is_range     = (w_hdr >= OPT_HDR_LO) && (w_hdr <= OPT_HDR_HI);
        o_cmd.len_id_ok    = (w_len >= ID_MIN_LEN);
        o_cmd.len_cfg_ok   = (w_len >= CFG_MIN_LEN);
        o_cmd.hold_ok      = (w_b0 >= HOLDOFF_MIN) && (w_b0 <= HOLDOFF_MAX);
        // identification fields
        o_cmd.id_version   = w_b0;
        o_cmd.manufacturer = {w_b1, w_b2};
        o_cmd.ext_flag     = w_b3[7];
        o_cmd.dev_id       = {w_b3[6:0], w_b4, w_b5};
        // configuration fields, windows in 4 ms steps
        o_cmd.ref_power    = w_b0[5:0];
        o_cmd.opt_count    = w_b2[2:0];
        o_cmd.win_size     = {w_b3[7:3], 2'b00};
        o_cmd.win_ok       = (w_b3[7:3] != 5'd0);
        o_cmd.win_offset   = {w_b3[2:0], 2'b00};
        o_cmd.fsk_depth    = w_b4[6:4];
        o_cmd.mode         = w_b4[7];
    end

endmodule

/* src/wpid_queue.sv */
`timescale 1ns / 1ps

module wpid_queue
    import wpid_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    input  t_cmd                               i_cmd,
    input  logic                               i_pop,
    output logic                               o_valid,
    output t_cmd                               o_cmd,
    output logic                               o_full,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   o_count
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == FULL_CNT);
    assign o_count = r_count;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

/* src/wpid_back.sv */
`timescale 1ns / 1ps

module wpid_back
    import wpid_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  t_cmd                  i_cmd,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [OUT_DATA_W-1:0] o_data
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_opt_seen, n_opt_seen;
    logic        r_mode, n_mode;
    logic [2:0]  r_fault, n_fault;
    logic [7:0]  r_id_version, n_id_version;
    logic [15:0] r_manufacturer, n_manufacturer;
    logic        r_ext_flag, n_ext_flag;
    logic [22:0] r_dev_id, n_dev_id;
    logic [5:0]  r_ref_power, n_ref_power;
    logic [6:0]  r_win_size, n_win_size;
    logic [4:0]  r_win_offset, n_win_offset;
    logic [2:0]  r_fsk_depth, n_fsk_depth;
    logic        n_done;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;

    logic        w_opt_path;
    logic        w_cfg_path;
    logic [7:0]  w_opt_inc;

    function automatic logic [2:0] phase_code(input t_phase ph);
        logic [2:0] code;
        unique case (ph)
            S_WAIT_ID:  code = PH_CODE_WAIT_ID;
            S_WAIT_XID: code = PH_CODE_WAIT_XID;
            S_OPTIONAL: code = PH_CODE_OPTIONAL;
            S_CONFIG:   code = PH_CODE_CONFIG;
            S_COMPLETE: code = PH_CODE_COMPLETE;
            default:    code = PH_CODE_ERROR;
        endcase
        return code;
    endfunction

    // output stage frees when empty or taken this cycle
    assign o_pop   = i_valid && (!r_out_valid || i_ready);
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    // optional handling: the optional phase, or a non extended packet while waiting for extended id
    assign w_opt_path = (r_phase == S_OPTIONAL) || ((r_phase == S_WAIT_XID) && !i_cmd.is_xid);
    // hold-off header takes priority over configuration
    assign w_cfg_path = (r_phase == S_CONFIG) || (w_opt_path && !i_cmd.is_hold && i_cmd.is_cfg);
    assign w_opt_inc  = (r_opt_seen != OPT_CNT_MAX) ? r_opt_seen + 8'd1 : r_opt_seen;

    always_comb begin
        n_phase        = r_phase;
        n_opt_seen     = r_opt_seen;
        n_mode         = r_mode;
        n_fault        = r_fault;
        n_id_version   = r_id_version;
        n_manufacturer = r_manufacturer;
        n_ext_flag     = r_ext_flag;
        n_dev_id       = r_dev_id;
        n_ref_power    = r_ref_power;
        n_win_size     = r_win_size;
        n_win_offset   = r_win_offset;
        n_fsk_depth    = r_fsk_depth;
        n_done         = 1'b0;

        if (i_cmd.restart) begin
            n_phase        = S_WAIT_ID;
            n_opt_seen     = '0;
            n_mode         = 1'b0;
            n_fault        = FLT_NONE;
            n_id_version   = '0;
            n_manufacturer = '0;
            n_ext_flag     = 1'b0;
            n_dev_id       = '0;
            n_ref_power    = '0;
            n_win_size     = '0;
            n_win_offset   = '0;
            n_fsk_depth    = '0;
        end else begin
            unique case (r_phase) inside
                S_WAIT_ID: begin
                    if (!i_cmd.is_id) begin
                        n_fault = FLT_UNEXPECTED;
                        n_phase = S_ERROR;
                    end else if (!i_cmd.len_id_ok) begin
                        n_fault = FLT_SHORT_ID;
                        n_phase = S_ERROR;
                    end else begin
                        n_id_version   = i_cmd.id_version;
                        n_manufacturer = i_cmd.manufacturer;
                        n_ext_flag     = i_cmd.ext_flag;
                        n_dev_id       = i_cmd.dev_id;
                        n_phase        = i_cmd.ext_flag ? S_WAIT_XID : S_OPTIONAL;
                    end
                end
                S_WAIT_XID, S_OPTIONAL, S_CONFIG: begin
                    if (r_phase == S_WAIT_XID) begin
                        n_phase = S_OPTIONAL;
                    end
                    if (w_cfg_path) begin
                        if (!i_cmd.is_cfg) begin
                            n_fault = FLT_UNEXPECTED;
                            n_phase = S_ERROR;
                        end else if (!i_cmd.len_cfg_ok) begin
                            n_fault = FLT_BAD_CFG;
                            n_phase = S_ERROR;
                        end else begin
                            // fields stay stored even when a later check fails
                            n_ref_power  = i_cmd.ref_power;
                            n_win_size   = i_cmd.win_size;
                            n_win_offset = i_cmd.win_offset;
                            n_fsk_depth  = i_cmd.fsk_depth;
                            if ({5'd0, i_cmd.opt_count} != r_opt_seen) begin
                                n_fault = FLT_COUNT;
                                n_phase = S_ERROR;
                            end else if (!i_cmd.win_ok) begin
                                n_fault = FLT_BAD_CFG;
                                n_phase = S_ERROR;
                            end else begin
                                n_mode  = i_cmd.mode;
                                n_phase = S_COMPLETE;
                                n_done  = 1'b1;
                            end
                        end
                    end else if (w_opt_path) begin
                        if (i_cmd.is_hold) begin
                            if (!i_cmd.hold_ok) begin
                                n_fault = FLT_HOLDOFF;
                                n_phase = S_ERROR;
                            end else begin
                                n_opt_seen = w_opt_inc;
                            end
                        end else if (i_cmd.is_range) begin
                            n_opt_seen = w_opt_inc;
                        end else begin
                            n_fault = FLT_UNEXPECTED;
                            n_phase = S_ERROR;
                        end
                    end
                end
                S_COMPLETE, S_ERROR: begin
                end
                default: begin
                end
            endcase
        end

        n_out_data = {3'b000, n_fsk_depth, n_win_offset, n_win_size, n_ref_power,
                      n_dev_id, n_ext_flag, n_manufacturer, n_id_version,
                      n_mode, n_fault, phase_code(n_phase), n_done};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= S_WAIT_ID;
            r_opt_seen     <= '0;
            r_mode         <= 1'b0;
            r_fault        <= FLT_NONE;
            r_id_version   <= '0;
            r_manufacturer <= '0;
            r_ext_flag     <= 1'b0;
            r_dev_id       <= '0;
            r_ref_power    <= '0;
            r_win_size     <= '0;
            r_win_offset   <= '0;
            r_fsk_depth    <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase        <= n_phase;
                r_opt_seen     <= n_opt_seen;
                r_mode         <= n_mode;
                r_fault        <= n_fault;
                r_id_version   <= n_id_version;
                r_manufacturer <= n_manufacturer;
                r_ext_flag     <= n_ext_flag;
                r_dev_id       <= n_dev_id;
                r_ref_power    <= n_ref_power;
                r_win_size     <= n_win_size;
                r_win_offset   <= n_win_offset;
                r_fsk_depth    <= n_fsk_depth;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

/* src/wireless_power_id_config_phase.sv */
`timescale 1ns / 1ps
// channel    | direction | handshake                     | content
// s_axis     | in        | s_axis_tvalid / s_axis_tready | one restart or one receiver packet
// m_axis     | out       | m_axis_tvalid / m_axis_tready | one status result per input transfer
//
// one packet per cycle sustained while m_axis_tready keeps up; a result is registered in the
// classification queue and then in the sequencer output register
// the queue holds QUEUE_DEPTH classified packets, so input keeps flowing while
// a result waits at the output; s_axis_tready drops only when the queue is full
// synchronous active-low reset puts the sequencer in wait-for-id with all fields zero

module wireless_power_id_config_phase
    import wpid_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [0] req_type
    input  logic                  s_axis_tuser,
    // [7:0] header, [15:8] pkt_length, [23:16] byte0, [31:24] byte1,
    // [39:32] byte2, [47:40] byte3, [55:48] byte4, [63:56] byte5
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] done_res, [3:1] phase, [6:4] fault, [7] epp_mode, [15:8] id_version,
    // [31:16] manufacturer, [32] extended_id_flag, [55:33] basic_device_id,
    // [61:56] ref power, [68:62] window_size_ms, [73:69] window_offset_ms,
    // [76:74] fsk_depth, [79:77] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

`include "wireless_power_id_config_phase_macros.svh"

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // front to queue
    logic                 w_push;
    t_cmd                 w_cmd_in;

    // queue to back
    logic                 w_q_valid;
    t_cmd                 w_q_cmd;
    logic                 w_q_full;
    logic [CNT_W-1:0]     w_q_count;
    logic                 w_pop;

    // result fields seen by the checks below
    logic                 w_out_done;
    logic [2:0]           w_out_phase;
    logic [2:0]           w_out_fault;

    assign s_axis_tready = ~w_q_full;

    // header and length decode plus field extraction
    wpid_front u_front (
        .i_valid    (s_axis_tvalid),
        .i_ready    (s_axis_tready),
        .i_req_type (s_axis_tuser),
        .i_data     (s_axis_tdata),
        .o_push     (w_push),
        .o_cmd      (w_cmd_in)
    );

    // short queue decoupling input acceptance from the sequencer
    wpid_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .o_full  (w_q_full),
        .o_count (w_q_count)
    );

    // phase sequencer, parsed registers and the output register
    wpid_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_cmd   (w_q_cmd),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

    assign w_out_done  = m_axis_tdata[0];
    assign w_out_phase = m_axis_tdata[3:1];
    assign w_out_fault = m_axis_tdata[6:4];

    // queue occupancy never exceeds its depth
    `WPID_ASSERT_ALWAYS(a_queue_bound, i_clk, i_rst_n, w_q_count <= CNT_W'(QUEUE_DEPTH), "queue overflow")
    // an error phase always carries a fault code
    `WPID_ASSERT_IMPLY(a_error_fault, i_clk, i_rst_n, m_axis_tvalid && (w_out_phase == PH_CODE_ERROR), w_out_fault != FLT_NONE, "error phase without fault")
    // completion reported only together with a clean complete phase
    `WPID_ASSERT_IMPLY(a_done_complete, i_clk, i_rst_n, m_axis_tvalid && w_out_done, (w_out_phase == PH_CODE_COMPLETE) && (w_out_fault == FLT_NONE), "done without completion")
    // the configuration phase is transient and never reported
    `WPID_ASSERT_IMPLY(a_no_cfg_hold, i_clk, i_rst_n, m_axis_tvalid, w_out_phase != PH_CODE_CONFIG, "configuration phase held")

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
    import wpid_pkg::*;

    // request kinds carried on s_axis_tuser
    localparam logic REQ_RESTART = 1'b0;
    localparam logic REQ_PACKET  = 1'b1;

    localparam int RANDOM_ITEMS = 1350;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;

    // result word, msb first, as it leaves the block
    typedef struct packed {
        logic [2:0]  pad;
        logic [2:0]  depth;
        logic [4:0]  win_offset;
        logic [6:0]  win_size;
        logic [5:0]  ref_power;
        logic [22:0] dev_id;
        logic        ext_flag;
        logic [15:0] manufacturer;
        logic [7:0]  id_version;
        logic        epp;
        logic [2:0]  fault;
        logic [2:0]  phase;
        logic        done;
    } t_status;

    // predicts the sequencer status for every accepted transfer and checks results in order
    class t_phase_scoreboard;
        t_status    state;
        logic [7:0] opt_seen;
        t_status    expected_status[$];
        int         failures;
        int         checked;
        int         completed;
        int         extended;
        int         saturated;
        int         fault_hits[8];

        function new();
            clear_state();
        endfunction

        function void clear_state();
            state       = '0;
            state.phase = PH_CODE_WAIT_ID;
            opt_seen    = '0;
        endfunction

        function void raise_fault(logic [2:0] code);
            state.fault = code;
            state.phase = PH_CODE_ERROR;
            fault_hits[code]++;
        endfunction

        function void bump_optional();
            if (opt_seen != OPT_CNT_MAX) begin
                opt_seen++;
                if (opt_seen == OPT_CNT_MAX) saturated++;
            end
        endfunction

        // payload byte k sits at pl[8k+7:8k]
        function logic take_config(logic [7:0] len, logic [47:0] pl);
            state.phase = PH_CODE_CONFIG;
            if (len < CFG_MIN_LEN) begin
                raise_fault(FLT_BAD_CFG);
                return 1'b0;
            end
            // stored even when a later check fails
            state.ref_power  = pl[5:0];
            state.win_size   = {pl[31:27], 2'b00};
            state.win_offset = {pl[26:24], 2'b00};
            state.depth      = pl[38:36];
            if (opt_seen != {5'd0, pl[18:16]}) begin
                raise_fault(FLT_COUNT);
                return 1'b0;
            end
            if (pl[31:27] == 5'd0) begin
                raise_fault(FLT_BAD_CFG);
                return 1'b0;
            end
            state.epp   = pl[39];
            state.phase = PH_CODE_COMPLETE;
            completed++;
            if (pl[39]) extended++;
            return 1'b1;
        endfunction

        function logic take_optional(logic [7:0] hdr, logic [7:0] len, logic [47:0] pl);
            if (hdr == HOLDOFF_HEADER) begin
                if (pl[7:0] < HOLDOFF_MIN || pl[7:0] > HOLDOFF_MAX) raise_fault(FLT_HOLDOFF);
                else bump_optional();
            end else if (hdr == CFG_HEADER) begin
                return take_config(len, pl);
            end else if (hdr >= OPT_HDR_LO && hdr <= OPT_HDR_HI) begin
                bump_optional();
            end else begin
                raise_fault(FLT_UNEXPECTED);
            end
            return 1'b0;
        endfunction

        function void note_packet(logic req, logic [63:0] data);
            logic [7:0]  hdr;
            logic [7:0]  len;
            logic [47:0] pl;
            hdr        = data[7:0];
            len        = data[15:8];
            pl         = data[63:16];
            state.done = 1'b0;
            if (req == REQ_RESTART) begin
                clear_state();
            end else begin
                case (state.phase)
                    PH_CODE_WAIT_ID: begin
                        if (hdr != ID_HEADER) begin
                            raise_fault(FLT_UNEXPECTED);
                        end else if (len < ID_MIN_LEN) begin
                            raise_fault(FLT_SHORT_ID);
                        end else begin
                            state.id_version   = pl[7:0];
                            state.manufacturer = {pl[15:8], pl[23:16]};
                            state.ext_flag     = pl[31];
                            state.dev_id       = {pl[30:24], pl[39:32], pl[47:40]};
                            state.phase = pl[31] ? PH_CODE_WAIT_XID : PH_CODE_OPTIONAL;
                        end
                    end
                    PH_CODE_WAIT_XID: begin
                        // anything but extended id is handled as optional right away
                        state.phase = PH_CODE_OPTIONAL;
                        if (hdr != XID_HEADER) state.done = take_optional(hdr, len, pl);
                    end
                    PH_CODE_OPTIONAL: state.done = take_optional(hdr, len, pl);
                    default: ;
                endcase
            end
            expected_status.push_back(state);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
                failures++;
            end
        endfunction

        function void check_status(logic [79:0] data);
            t_status got;
            t_status want;
            got = t_status'(data);
            if (expected_status.size() == 0) begin
                $display("%0t: result %h with nothing outstanding", $time, data);
                failures++;
                return;
            end
            want = expected_status.pop_front();
            checked++;
            compare_field("done_res", 32'(want.done), 32'(got.done));
            compare_field("phase", 32'(want.phase), 32'(got.phase));
            compare_field("fault", 32'(want.fault), 32'(got.fault));
            compare_field("epp_mode", 32'(want.epp), 32'(got.epp));
            compare_field("id_version", 32'(want.id_version), 32'(got.id_version));
            compare_field("manufacturer", 32'(want.manufacturer), 32'(got.manufacturer));
            compare_field("extended_id_flag", 32'(want.ext_flag), 32'(got.ext_flag));
            compare_field("basic_device_id", 32'(want.dev_id), 32'(got.dev_id));
            compare_field("ref_power", 32'(want.ref_power), 32'(got.ref_power));
            compare_field("window_size_ms", 32'(want.win_size), 32'(got.win_size));
            compare_field("window_offset_ms", 32'(want.win_offset), 32'(got.win_offset));
            compare_field("fsk_depth", 32'(want.depth), 32'(got.depth));
            compare_field("padding", 32'(want.pad), 32'(got.pad));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic        s_axis_tuser;      // [0] req_type
    logic [63:0] s_axis_tdata;      // [7:0] header, [15:8] pkt_length, [63:16] byte0..byte5
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;      // [0] done_res .. [76:74] fsk_depth, [79:77] zero

    t_phase_scoreboard sb = new();

    int sent_count;
    int burst_left;
    int cycle_count;
    bit hold_req;

    wireless_power_id_config_phase u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // results are checked before the input of the same edge is noted
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_status(m_axis_tdata);
        if (i_rst_n && s_axis_tvalid && s_axis_tready) sb.note_packet(s_axis_tuser, s_axis_tdata);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run timed out with %0d results outstanding", $time,
                     sb.expected_status.size());
            $display("tb: failure");
            $finish;
        end
    end

    // receiver: stall pattern switches at random among four, one long hold-off on request
    initial begin
        int mode;
        int mode_left;
        int tick;
        mode          = 0;
        mode_left     = 0;
        tick          = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req      = 1'b0;
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                tick++;
                case (mode)
                    0: m_axis_tready = 1'b1;
                    1: m_axis_tready = 1'($urandom_range(0, 1));
                    2: m_axis_tready = ($urandom_range(0, 3) == 0);
                    default: m_axis_tready = (tick % 4 != 3);
                endcase
            end
        end
    end

    // one transfer, then either keep the burst going or drop tvalid for a random gap
    task automatic send_packet(input logic req, input logic [7:0] hdr, input logic [7:0] len,
                               input logic [47:0] pl);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = req;
        s_axis_tdata  = {pl, len, hdr};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        sent_count++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(0, 12);
        end
    endtask

    function automatic logic [47:0] noise48();
        return {16'($urandom), $urandom};
    endfunction

    function automatic logic [47:0] id_payload(logic [7:0] ver, logic [15:0] manuf, logic ext,
                                               logic [22:0] basic);
        return {basic[7:0], basic[15:8], ext, basic[22:16], manuf[7:0], manuf[15:8], ver};
    endfunction

    // unused bits of the configuration bytes are filled at random
    function automatic logic [47:0] cfg_payload(logic [5:0] refp, logic [2:0] count,
                                                logic [4:0] win, logic [2:0] off,
                                                logic [2:0] depth, logic epp);
        logic [47:0] fill;
        fill = noise48();
        return {fill[47:40], epp, depth, fill[35:32], win, off, fill[23:19], count,
                fill[15:8], fill[7:6], refp};
    endfunction

    function automatic logic [47:0] holdoff_payload(logic [7:0] holdoff);
        logic [47:0] fill;
        fill = noise48();
        return {fill[47:8], holdoff};
    endfunction

    task automatic send_optional();
        int          pick;
        logic [7:0]  holdoff;
        pick = $urandom_range(0, 19);
        if (pick < 9) begin
            if ($urandom_range(0, 9) != 0) holdoff = 8'($urandom_range(5, 100));
            else if ($urandom_range(0, 1) != 0) holdoff = 8'($urandom_range(0, 4));
            else holdoff = 8'($urandom_range(101, 255));
            send_packet(REQ_PACKET, HOLDOFF_HEADER, 8'($urandom), holdoff_payload(holdoff));
        end else if (pick < 18) begin
            send_packet(REQ_PACKET, 8'($urandom_range(OPT_HDR_LO, OPT_HDR_HI)), 8'($urandom),
                        noise48());
        end else begin
            send_packet(REQ_PACKET, 8'($urandom), 8'($urandom), noise48());
        end
    endtask

    // mostly well-formed phases with random content, some broken on purpose
    task automatic random_session(input bit saturate);
        int          n_opt;
        logic        ext;
        logic [7:0]  hdr;
        logic [7:0]  len;
        logic [2:0]  count;
        logic [4:0]  win;
        if ($urandom_range(0, 9) != 0)
            send_packet(REQ_RESTART, 8'($urandom), 8'($urandom), noise48());
        ext = 1'($urandom_range(0, 1));
        hdr = ($urandom_range(0, 12) == 0) ? 8'($urandom) : ID_HEADER;
        len = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 5))
                                          : 8'($urandom_range(6, 255));
        send_packet(REQ_PACKET, hdr, len,
                    id_payload(8'($urandom), 16'($urandom), ext, 23'($urandom)));
        // extended id content is never checked by the block
        if (ext && $urandom_range(0, 6) != 0)
            send_packet(REQ_PACKET, XID_HEADER, 8'($urandom), noise48());
        n_opt = saturate ? $urandom_range(255, 262) : $urandom_range(0, 7);
        for (int i = 0; i < n_opt; i++) send_optional();
        count = ($urandom_range(0, 6) == 0) ? 3'($urandom) : 3'(n_opt);
        win   = ($urandom_range(0, 9) == 0) ? 5'd0 : 5'($urandom);
        len   = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 4))
                                            : 8'($urandom_range(5, 255));
        hdr   = ($urandom_range(0, 15) == 0) ? 8'($urandom) : CFG_HEADER;
        send_packet(REQ_PACKET, hdr, len,
                    cfg_payload(6'($urandom), count, win, 3'($urandom), 3'($urandom),
                                1'($urandom)));
        // stray packets after the phase has ended
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 2))
                send_packet(REQ_PACKET, 8'($urandom), 8'($urandom), noise48());
        end
    endtask

    initial begin
        int sessions;
        int target;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = REQ_RESTART;
        s_axis_tdata  = '0;
        sent_count    = 0;
        burst_left    = 0;
        hold_req      = 1'b0;
        sessions      = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // restart ignores its data
        send_packet(REQ_RESTART, 8'hFF, 8'hFF, '1);
        // wrong first header, then a packet while in error is ignored
        send_packet(REQ_PACKET, CFG_HEADER, 8'd6, id_payload(8'h12, 16'h3456, 1'b0, 23'h1));
        send_packet(REQ_PACKET, ID_HEADER, 8'd6, id_payload(8'h12, 16'h3456, 1'b0, 23'h1));
        // id one byte short
        send_packet(REQ_RESTART, 8'h00, 8'h00, '0);
        send_packet(REQ_PACKET, ID_HEADER, 8'd5, id_payload(8'hFF, 16'hFFFF, 1'b0, '1));
        // full phase with extended id, hold-off limits, optional range ends, all fields maxed
        send_packet(REQ_RESTART, 8'h00, 8'h00, '0);
        send_packet(REQ_PACKET, ID_HEADER, 8'd255, id_payload(8'hFF, 16'hFFFF, 1'b1, '1));
        send_packet(REQ_PACKET, XID_HEADER, 8'd0, '1);
        send_packet(REQ_PACKET, HOLDOFF_HEADER, 8'd1, holdoff_payload(HOLDOFF_MIN));
        send_packet(REQ_PACKET, HOLDOFF_HEADER, 8'd1, holdoff_payload(HOLDOFF_MAX));
        send_packet(REQ_PACKET, OPT_HDR_LO, 8'd0, '0);
        send_packet(REQ_PACKET, OPT_HDR_HI, 8'd255, '1);
        send_packet(REQ_PACKET, CFG_HEADER, CFG_MIN_LEN,
                    cfg_payload(6'h3F, 3'd4, 5'h1F, 3'h7, 3'h7, 1'b1));
        // anything after completion is ignored
        send_packet(REQ_PACKET, ID_HEADER, 8'd6, id_payload(8'h00, 16'h0000, 1'b0, '0));
        // extended id announced but configuration arrives directly, smallest window
        send_packet(REQ_RESTART, 8'hFF, 8'hFF, '1);
        send_packet(REQ_PACKET, ID_HEADER, ID_MIN_LEN, id_payload(8'h00, 16'h0000, 1'b1, '0));
        send_packet(REQ_PACKET, CFG_HEADER, 8'd255,
                    cfg_payload(6'h00, 3'd0, 5'h01, 3'h0, 3'h0, 1'b0));
        // count mismatch keeps the parsed configuration fields
        send_packet(REQ_RESTART, 8'h00, 8'h00, '0);
        send_packet(REQ_PACKET, ID_HEADER, 8'd6, id_payload(8'hA5, 16'h5AA5, 1'b0, 23'h2AAAAA));
        send_packet(REQ_PACKET, CFG_HEADER, 8'd5,
                    cfg_payload(6'h15, 3'd3, 5'h0A, 3'h5, 3'h2, 1'b1));
        // zero window size
        send_packet(REQ_RESTART, 8'h00, 8'h00, '0);
        send_packet(REQ_PACKET, ID_HEADER, 8'd6, id_payload(8'h5A, 16'hA55A, 1'b0, 23'h555555));
        send_packet(REQ_PACKET, CFG_HEADER, 8'd6,
                    cfg_payload(6'h2A, 3'd0, 5'h00, 3'h3, 3'h5, 1'b1));
        // hold-off just below its range
        send_packet(REQ_RESTART, 8'h00, 8'h00, '0);
        send_packet(REQ_PACKET, ID_HEADER, 8'd6, id_payload(8'h21, 16'h0102, 1'b0, 23'h30405));
        send_packet(REQ_PACKET, HOLDOFF_HEADER, 8'd1, holdoff_payload(HOLDOFF_MIN - 8'd1));

        // long receiver hold-off while the sender keeps offering, so the input backs up
        hold_req   = 1'b1;
        burst_left = 400;
        target     = sent_count + RANDOM_ITEMS;
        while (sent_count < target) begin
            random_session(sessions == 5 || sessions == 60);
            sessions++;
        end
        s_axis_tvalid = 1'b0;

        while (sb.expected_status.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d transfers sent, %0d results checked, %0d phases completed (%0d extended), %0d optional count saturations",
                 sent_count, sb.checked, sb.completed, sb.extended, sb.saturated);
        $display("faults: short id %0d, bad config %0d, count %0d, hold-off %0d, unexpected %0d"
                 , sb.fault_hits[FLT_SHORT_ID], sb.fault_hits[FLT_BAD_CFG],
                 sb.fault_hits[FLT_COUNT], sb.fault_hits[FLT_HOLDOFF],
                 sb.fault_hits[FLT_UNEXPECTED]);
        if (sb.failures == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/wpid_pkg.sv
src/wpid_front.sv
src/wpid_queue.sv
src/wpid_back.sv
src/wireless_power_id_config_phase.sv
test/tb.sv
